// ===== hdl/tmq_pkg.sv =====
// Shared constants, codes and control types of the deadline timer queue.
package tmq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int ID_BITS_DEF   = 16;

    localparam int MAX_SLOTS   = 16;
    localparam int SLOT_BITS   = 4;
    localparam int GEN_BITS    = 4;
    localparam int CNT_BITS    = 5;
    localparam int HANDLE_BITS = SLOT_BITS + GEN_BITS;
    localparam int FUNC_BITS   = 2;
    localparam int KIND_BITS   = 3;

    localparam logic [FUNC_BITS-1:0] FN_ADD     = 2'd0;
    localparam logic [FUNC_BITS-1:0] FN_DISMISS = 2'd1;
    localparam logic [FUNC_BITS-1:0] FN_PROCESS = 2'd2;

    localparam logic [KIND_BITS-1:0] KD_ADDED     = 3'd0;
    localparam logic [KIND_BITS-1:0] KD_DISMISSED = 3'd1;
    localparam logic [KIND_BITS-1:0] KD_FIRED     = 3'd2;
    localparam logic [KIND_BITS-1:0] KD_NONE_DUE  = 3'd3;
    localparam logic [KIND_BITS-1:0] KD_FULL      = 3'd4;
    localparam logic [KIND_BITS-1:0] KD_STALE     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_ADD_SCAN,
        ST_ADD_PUT,
        ST_DIS,
        ST_PROC
    } t_state;

    // Order list command: insert slot at pos, or remove the entry at pos.
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [SLOT_BITS-1:0] pos;
        logic [SLOT_BITS-1:0] slot;
    } t_ord_cmd;

    // Order list status.
    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic [SLOT_BITS-1:0] rd_slot;
        logic [SLOT_BITS-1:0] find_pos;
    } t_ord_stat;

endpackage

// ===== hdl/tmq_cmp.sv =====
// Shared deadline comparator: less-than or less-or-equal by one subtraction.
module tmq_cmp import tmq_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0] i_a,
    input  logic [TIME_BITS-1:0] i_b,
    input  logic                 i_strict,
    output logic                 o_res
);

    logic [TIME_BITS:0] w_diff;
    logic               w_eq;

    // borrow set means a > b
    assign w_diff = {1'b0, i_b} - {1'b0, i_a};
    assign w_eq   = (i_a == i_b);
    assign o_res  = !w_diff[TIME_BITS] && !(i_strict && w_eq);

endmodule

// ===== hdl/tmq_order.sv =====
// Firing order list: slots in deadline order with insert, remove and slot lookup.
module tmq_order import tmq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ord_cmd             i_cmd,
    input  logic [SLOT_BITS-1:0] i_rd_pos,
    input  logic [SLOT_BITS-1:0] i_find_slot,
    output t_ord_stat            o_stat
);

    localparam int CAP    = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
    localparam int SLOT_W = $clog2(CAP);

    logic [SLOT_BITS-1:0] r_list [CAP];
    logic [SLOT_BITS-1:0] n_list [CAP];
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic [SLOT_BITS-1:0] w_find;

    always_comb begin
        n_list = r_list;
        if (i_cmd.ins) begin
            for (int i = 1; i < CAP; i++) begin
                if (SLOT_BITS'(i) > i_cmd.pos) n_list[i] = r_list[i-1];
            end
            n_list[i_cmd.pos[SLOT_W-1:0]] = i_cmd.slot;
        end else if (i_cmd.rem) begin
            for (int i = 0; i < CAP - 1; i++) begin
                if (SLOT_BITS'(i) >= i_cmd.pos) n_list[i] = r_list[i+1];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins) n_count = r_count + CNT_BITS'(1);
        else if (i_cmd.rem) n_count = r_count - CNT_BITS'(1);
    end

    // each slot sits at most once among the occupied positions
    always_comb begin
        w_find = '0;
        for (int i = 0; i < CAP; i++) begin
            if ((r_list[i] == i_find_slot) && (CNT_BITS'(i) < r_count)) w_find = SLOT_BITS'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    assign o_stat.count    = r_count;
    assign o_stat.rd_slot  = r_list[i_rd_pos[SLOT_W-1:0]];
    assign o_stat.find_pos = w_find;

endmodule

// ===== hdl/deadline_timer_queue_top.sv =====
// Top level of the deadline timer queue: sequencer, slot store and result register.
//
// The block holds up to min(DEPTH, 16) pending timeouts in deadline order and
// takes one transaction at a time; s_axis_tready is high only while the
// sequencer is idle. All deadline tests go through one shared comparator,
// one entry per cycle unless the result register waits on m_axis_tready. An
// add first checks for room, then its insertion scan walks the order list
// from its head past the pending entries whose deadline is at or before the
// new one, then it inserts; an add to a full queue skips the scan. A dismiss
// checks the handle and retires a matching entry; a process compares and
// retires each due head entry in turn. Any of these stretches while the
// result register waits on m_axis_tready. The result register lets a
// finished result wait while the sequencer moves on. A handle is the slot in
// bits 3..0 and the slot's generation in bits 7..4; the generation advances
// whenever the entry leaves, so an old handle reads as stale. Operation code
// 3 is dropped with no result.
module deadline_timer_queue_top import tmq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // time_req, handle, callback_id (lowest bit up), zero padded to bytes
    input  logic [((TIME_BITS+HANDLE_BITS+ID_BITS+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic [FUNC_BITS-1:0]                          s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // out_handle, fired_id (lowest bit up), zero padded to bytes
    output logic [((HANDLE_BITS+ID_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // kind
    output logic [KIND_BITS-1:0]                          m_axis_tuser,
    // last
    output logic                                          m_axis_tlast
);

    localparam int CAP    = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
    localparam int SLOT_W = $clog2(CAP);
    localparam int OUT_W  = ((HANDLE_BITS + ID_BITS + 7) / 8) * 8;

    // ---------------------------------------------------------------- state
    t_state r_state;
    t_state n_state;

    // latched transaction
    logic [FUNC_BITS-1:0]   r_func;
    logic [TIME_BITS-1:0]   r_time;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [ID_BITS-1:0]     r_cid;
    logic [SLOT_BITS-1:0]   r_slot;   // dismiss target, then free slot of an add
    logic [SLOT_BITS-1:0]   r_pos;    // scan position in the order list

    // slot store
    logic [TIME_BITS-1:0] r_dl    [CAP];
    logic [ID_BITS-1:0]   r_ids   [CAP];
    logic [GEN_BITS-1:0]  r_gen   [CAP];
    logic                 r_valid [CAP];

    // fired entry held until the next compare tells whether it is the last
    logic                   r_have;
    logic [HANDLE_BITS-1:0] r_hold_handle;
    logic [ID_BITS-1:0]     r_hold_id;

    // result register
    logic                   r_m_valid;
    logic [KIND_BITS-1:0]   r_kind;
    logic [HANDLE_BITS-1:0] r_ohandle;
    logic [ID_BITS-1:0]     r_fid;
    logic                   r_last;

    // ------------------------------------------------------------- datapath
    t_ord_cmd  w_ord_cmd;
    t_ord_stat w_ord;
    logic      w_s_acc;
    logic      w_o_free;
    logic      w_cmp_res;
    logic      w_head_due;
    logic      w_scan_go;
    logic      w_full;
    logic      w_slot_ok;
    logic      w_any_free;

    logic [SLOT_BITS-1:0] w_free_slot;
    logic [SLOT_W-1:0]    w_rd_idx;
    logic [SLOT_W-1:0]    w_cur_idx;

    // sequencer actions
    logic                   w_emit;
    logic [KIND_BITS-1:0]   w_e_kind;
    logic [HANDLE_BITS-1:0] w_e_handle;
    logic [ID_BITS-1:0]     w_e_id;
    logic                   w_e_last;
    logic                   w_insert;
    logic                   w_retire;
    logic                   w_pos_inc;
    logic                   w_hold_load;
    logic                   w_have_clr;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_o_free      = !r_m_valid || m_axis_tready;

    tmq_order #(
        .DEPTH (DEPTH)
    ) u_order (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_ord_cmd),
        .i_rd_pos    (r_pos),
        .i_find_slot (r_slot),
        .o_stat      (w_ord)
    );

    // r_pos stays at zero during a process, so rd_slot is then the head
    assign w_rd_idx  = w_ord.rd_slot[SLOT_W-1:0];
    assign w_cur_idx = (r_state == ST_PROC) ? w_ord.rd_slot[SLOT_W-1:0]
                                            : r_slot[SLOT_W-1:0];

    // one comparator: deadline <= t while scanning an add, deadline < t on process
    tmq_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .i_a      (r_dl[w_rd_idx]),
        .i_b      (r_time),
        .i_strict (r_state == ST_PROC),
        .o_res    (w_cmp_res)
    );

    assign w_head_due = (w_ord.count != '0) && w_cmp_res;
    assign w_scan_go  = ({1'b0, r_pos} < w_ord.count) && w_cmp_res;

    // lowest free slot
    always_comb begin
        w_free_slot = '0;
        w_any_free  = 1'b0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_slot = SLOT_BITS'(i);
                w_any_free  = 1'b1;
            end
        end
    end

    assign w_full    = (w_ord.count >= CNT_BITS'(CAP)) || !w_any_free;
    assign w_slot_ok = ({1'b0, r_slot} < CNT_BITS'(CAP)) && r_valid[w_cur_idx] &&
                       (r_gen[w_cur_idx] == r_handle[HANDLE_BITS-1:SLOT_BITS]);

    // ----------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    unique case (s_axis_tuser)
                        FN_ADD:     n_state = ST_ADD_CHK;
                        FN_DISMISS: n_state = ST_DIS;
                        FN_PROCESS: n_state = ST_PROC;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_CHK: begin
                if (!w_full) n_state = ST_ADD_SCAN;
                else if (w_o_free) n_state = ST_IDLE;
            end
            ST_ADD_SCAN: begin
                if (!w_scan_go) n_state = ST_ADD_PUT;
            end
            ST_ADD_PUT: begin
                if (w_o_free) n_state = ST_IDLE;
            end
            ST_DIS: begin
                if (w_o_free) n_state = ST_IDLE;
            end
            ST_PROC: begin
                if (!w_head_due && w_o_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------ sequencer actions
    always_comb begin
        w_emit      = 1'b0;
        w_e_kind    = KD_ADDED;
        w_e_handle  = '0;
        w_e_id      = '0;
        w_e_last    = 1'b1;
        w_insert    = 1'b0;
        w_retire    = 1'b0;
        w_pos_inc   = 1'b0;
        w_hold_load = 1'b0;
        w_have_clr  = 1'b0;
        w_ord_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_ADD_CHK: begin
                if (w_full && w_o_free) begin
                    w_emit   = 1'b1;
                    w_e_kind = KD_FULL;
                end
            end
            ST_ADD_SCAN: begin
                w_pos_inc = w_scan_go;
            end
            ST_ADD_PUT: begin
                if (w_o_free) begin
                    w_emit         = 1'b1;
                    w_e_kind       = KD_ADDED;
                    w_e_handle     = {r_gen[w_cur_idx], r_slot};
                    w_insert       = 1'b1;
                    w_ord_cmd.ins  = 1'b1;
                    w_ord_cmd.pos  = r_pos;
                    w_ord_cmd.slot = r_slot;
                end
            end
            ST_DIS: begin
                if (w_o_free) begin
                    w_emit     = 1'b1;
                    w_e_handle = r_handle;
                    if (w_slot_ok) begin
                        w_e_kind      = KD_DISMISSED;
                        w_e_id        = r_ids[w_cur_idx];
                        w_retire      = 1'b1;
                        w_ord_cmd.rem = 1'b1;
                        w_ord_cmd.pos = w_ord.find_pos;
                    end else begin
                        w_e_kind = KD_STALE;
                    end
                end
            end
            ST_PROC: begin
                if (w_head_due) begin
                    // pass the held entry on before retiring the next head
                    if (!r_have || w_o_free) begin
                        w_emit        = r_have;
                        w_e_kind      = KD_FIRED;
                        w_e_handle    = r_hold_handle;
                        w_e_id        = r_hold_id;
                        w_e_last      = 1'b0;
                        w_hold_load   = 1'b1;
                        w_retire      = 1'b1;
                        w_ord_cmd.rem = 1'b1;
                        w_ord_cmd.pos = '0;
                    end
                end else if (w_o_free) begin
                    w_emit     = 1'b1;
                    w_have_clr = 1'b1;
                    if (r_have) begin
                        w_e_kind   = KD_FIRED;
                        w_e_handle = r_hold_handle;
                        w_e_id     = r_hold_id;
                    end else begin
                        w_e_kind = KD_NONE_DUE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_have    <= 1'b0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < CAP; i++) begin
                r_valid[i] <= 1'b0;
                r_gen[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_hold_load) r_have <= 1'b1;
            else if (w_have_clr) r_have <= 1'b0;
            if (w_emit) r_m_valid <= 1'b1;
            else if (m_axis_tready) r_m_valid <= 1'b0;
            if (w_insert) r_valid[r_slot[SLOT_W-1:0]] <= 1'b1;
            // free the slot and advance its generation so old handles go stale
            if (w_retire) begin
                r_valid[w_cur_idx] <= 1'b0;
                r_gen[w_cur_idx]   <= r_gen[w_cur_idx] + GEN_BITS'(1);
            end
        end
    end

    // ------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_func   <= s_axis_tuser;
            r_time   <= s_axis_tdata[TIME_BITS-1:0];
            r_handle <= s_axis_tdata[TIME_BITS+HANDLE_BITS-1:TIME_BITS];
            r_cid    <= s_axis_tdata[TIME_BITS+HANDLE_BITS+ID_BITS-1:TIME_BITS+HANDLE_BITS];
            r_slot   <= s_axis_tdata[TIME_BITS+SLOT_BITS-1:TIME_BITS];
            r_pos    <= '0;
        end else if ((r_state == ST_ADD_CHK) && (r_func == FN_ADD)) begin
            r_slot <= w_free_slot;
            r_pos  <= '0;
        end else if (w_pos_inc) begin
            r_pos <= r_pos + SLOT_BITS'(1);
        end

        if (w_insert) begin
            r_dl[r_slot[SLOT_W-1:0]]  <= r_time;
            r_ids[r_slot[SLOT_W-1:0]] <= r_cid;
        end

        // capture the head before its generation advances
        if (w_hold_load) begin
            r_hold_handle <= {r_gen[w_cur_idx], w_ord.rd_slot};
            r_hold_id     <= r_ids[w_cur_idx];
        end

        if (w_emit) begin
            r_kind    <= w_e_kind;
            r_ohandle <= w_e_handle;
            r_fid     <= w_e_id;
            r_last    <= w_e_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_fid, r_ohandle});
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

endmodule
